// ----- hw/rtl/tw_dot_pkg.sv -----
// Shared types, constants and helpers for the ternary-weight dot product.
// No dependencies; imported by every module under hw/rtl.
`timescale 1ns / 1ps

package tw_dot_pkg;

  localparam int CODES_PER_BYTE = 4;
  localparam int LANE_COUNT     = 4;
  localparam int ACT_W          = 8;
  localparam int CODE_W         = 2;
  localparam int LANES_W        = 3;
  localparam int SUM_W          = 32;
  // Four lanes of +/-128 at most: |sum| <= 512, which needs 11 signed bits.
  localparam int LANE_SUM_W     = 11;

  localparam int LANE_CAP = (CODES_PER_BYTE < LANE_COUNT) ? CODES_PER_BYTE : LANE_COUNT;

  typedef enum logic [CODE_W-1:0] {
    CODE_ZERO  = 2'd0,
    CODE_PLUS  = 2'd1,
    CODE_MINUS = 2'd2,
    CODE_NONE  = 2'd3
  } weight_code_t;

  typedef logic [LANE_COUNT-1:0][ACT_W-1:0] act_vec_t;
  typedef logic [LANE_COUNT*CODE_W-1:0]     code_vec_t;
  typedef logic [LANES_W-1:0]               lanes_t;
  typedef logic signed [LANE_SUM_W-1:0]     lane_sum_t;
  typedef logic signed [SUM_W-1:0]          sum_t;

  // Control that travels with an item from the input register to the accumulator.
  typedef struct packed {
    logic valid;
    logic last;
  } item_ctl_t;

  // Clamp the lane count to what the packed byte can carry.
  function automatic lanes_t lane_limit(input lanes_t lanes_used);
    lanes_t cap;
    cap = LANES_W'(LANE_CAP);
    return (lanes_used > cap) ? cap : lanes_used;
  endfunction

endpackage

// ----- hw/rtl/tw_dot_lanes.sv -----
// Lane decode and adder tree: one item's four signed terms summed.
// Depends on tw_dot_pkg.
`timescale 1ns / 1ps

module tw_dot_lanes (
  input  tw_dot_pkg::act_vec_t  acts,
  input  tw_dot_pkg::code_vec_t codes,
  input  tw_dot_pkg::lanes_t    lanes_used,
  output tw_dot_pkg::lane_sum_t lane_sum
);
  import tw_dot_pkg::*;

  lane_sum_t    term [LANE_COUNT];
  lanes_t       lane_count;

  assign lane_count = lane_limit(lanes_used);

  always_comb begin
    for (int i = 0; i < LANE_COUNT; i++) begin
      lane_sum_t    a;
      weight_code_t code;
      a    = LANE_SUM_W'(signed'(acts[i]));
      code = weight_code_t'(codes[i*CODE_W +: CODE_W]);
      term[i] = '0;
      // Drop padding lanes; true product kept, so -(-128) is +128.
      if (LANES_W'(i) < lane_count) begin
        case (code)
          CODE_PLUS:  term[i] = a;
          CODE_MINUS: term[i] = -a;
          default:    term[i] = '0;
        endcase
      end
    end
  end

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      lane_sum = lane_sum + term[i];
    end
  end

endmodule

// ----- hw/rtl/tw_dot_accum.sv -----
// Running-sum accumulator and result register with valid/ready output.
// Depends on tw_dot_pkg.
`timescale 1ns / 1ps

module tw_dot_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  tw_dot_pkg::item_ctl_t item,
  input  tw_dot_pkg::lane_sum_t lane_sum,
  output logic                  take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tw_dot_pkg::sum_t      dot_sum
);
  import tw_dot_pkg::*;

  sum_t running_sum;
  sum_t running_sum_next;

  // Non-last items never wait; a last item waits for a free result register.
  assign take = item.valid && (!item.last || !out_valid || out_ready);

  assign running_sum_next = running_sum + SUM_W'(lane_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else if (take && item.last) begin
      running_sum <= '0;
      out_valid   <= 1'b1;
    end else begin
      if (take) begin
        running_sum <= running_sum_next;
      end
      if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last) begin
      dot_sum <= running_sum_next;
    end
  end

endmodule

// ----- hw/rtl/ternary_weight_dot_product.sv -----
// Ternary-weight dot product: signed 8-bit activations times 2-bit packed weights.
// dot_sum is registered: a last item passes the input register, then the result register.
// Throughput: one item per cycle unless a last item stalls; input register, lane adder tree and one 32-bit add.
// A last item stalls only while a previous result is still held on the output.
// Reset (rst, synchronous, active high) clears both valid flags and the running sum.
// Depends on tw_dot_pkg, tw_dot_lanes and tw_dot_accum.
`timescale 1ns / 1ps

module ternary_weight_dot_product (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  act_0,
  input  logic [7:0]  act_1,
  input  logic [7:0]  act_2,
  input  logic [7:0]  act_3,
  input  logic [7:0]  weight_codes,
  input  logic [2:0]  lanes_used,
  input  logic        last_element,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] dot_sum
);
  import tw_dot_pkg::*;

  // Input register: holds one accepted item until the accumulator takes it.
  item_ctl_t s1_ctl;
  act_vec_t  s1_acts;
  code_vec_t s1_codes;
  lanes_t    s1_lanes;

  lane_sum_t lane_sum;
  sum_t      sum_out;
  logic      take;

  // Accept a new item whenever the input register is empty or drains this cycle.
  assign in_ready = !s1_ctl.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (in_ready) begin
      s1_ctl.valid <= in_valid;
      s1_ctl.last  <= last_element;
    end
  end

  // Payload needs no reset; load only on acceptance.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_acts  <= {act_3, act_2, act_1, act_0};
      s1_codes <= weight_codes;
      s1_lanes <= lanes_used;
    end
  end

  // Decode the four weight codes and sum the live lanes.
  tw_dot_lanes u_lanes (
    .acts       (s1_acts),
    .codes      (s1_codes),
    .lanes_used (s1_lanes),
    .lane_sum   (lane_sum)
  );

  // Fold into the running sum; on a last item, hand the total to the result register.
  tw_dot_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .item      (s1_ctl),
    .lane_sum  (lane_sum),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dot_sum   (sum_out)
  );

  assign dot_sum = sum_out;

`ifndef SYNTHESIS
  // A non-last item in the input register never stalls.
  assert property (@(posedge clk) disable iff (rst)
    (s1_ctl.valid && !s1_ctl.last) |-> take)
    else $error("non-last item stalled in input register");

  // A last item taken by the accumulator shows up as a result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (take && s1_ctl.last) |=> out_valid)
    else $error("last item produced no result");

  // A held result with a waiting last item blocks that item.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && s1_ctl.valid && s1_ctl.last) |-> !take)
    else $error("result register overwritten while held");

  // Nothing valid right after reset.
  assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_ctl.valid))
    else $error("valid flag set after reset");
`endif

endmodule
